// ===== rtl/gwpm_pkg.sv =====
// Shared types and constants for the grid window peak marker.
// Used by every module of the block; has no dependencies of its own.
package gwpm_pkg;

   localparam int COORD_W        = 12;
   localparam int CFG_W          = 13;
   localparam int DRAIN_W        = 13;
   localparam int WIDTH_LIMIT    = 4096;
   localparam int MAX_RESULTS    = 2;
   localparam int RSP_FIFO_DEPTH = 8;
   localparam int RSP_FIFO_AW    = 3;
   localparam int RSP_TDATA_W    = 32;

   localparam logic [CFG_W-1:0] DIM_MIN    = 13'd2;
   localparam logic [CFG_W-1:0] DIM_RESET  = 13'd1024;
   localparam logic [CFG_W-1:0] HEIGHT_MAX = 13'd4096;

   // register indexes on the csr port
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   // req_tuser codes
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_DRAIN  = 1'b1;

   // one accepted beat, as handed from the sequencer to the window stage
   typedef struct packed {
      logic               drain;
      logic               hit;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               last_col;
      logic               bank;
      logic               frame_last;
   } cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_row;
      logic [COORD_W-1:0] pixel_col;
      logic               peak_flag;
      logic               frame_last;
   } result_type;

   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] value,
                                                   input logic [CFG_W-1:0] limit);
      logic [CFG_W-1:0] result;
      if (value < DIM_MIN) begin
         result = DIM_MIN;
      end else if (value > limit) begin
         result = limit;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

// ===== rtl/gwpm_line_mem.sv =====
// Two-bank line memory: per column the height of one row and two window marks.
// One write port, two read ports with registered, write-first read data. Uses gwpm_pkg.
module gwpm_line_mem
   import gwpm_pkg::*;
#(
   parameter int LINE_AW     = 12,
   parameter int HEIGHT_BITS = 32
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [LINE_AW:0]       wr_addr,
   input  logic [HEIGHT_BITS-1:0] wr_height,
   input  logic                   wr_mark_l,
   input  logic                   wr_mark_r,
   input  logic [LINE_AW:0]       rd_addr_a,
   input  logic [LINE_AW:0]       rd_addr_b,
   output logic [HEIGHT_BITS-1:0] rd_a_height,
   output logic                   rd_a_mark_l,
   output logic                   rd_a_mark_r,
   output logic                   rd_b_mark_l
);

   localparam int WORD_W  = HEIGHT_BITS + 2;
   localparam int ENTRIES = 2 ** (LINE_AW + 1);

   logic [WORD_W-1:0] line_ff [ENTRIES];
   logic [WORD_W-1:0] wr_word;
   logic [WORD_W-1:0] rd_a_ff, rd_a_in;
   logic [WORD_W-1:0] rd_b_ff, rd_b_in;

   assign wr_word = {wr_height, wr_mark_l, wr_mark_r};

   // a read of the entry being written returns the new word
   always_comb begin
      rd_a_in = (wr_en && (wr_addr == rd_addr_a)) ? wr_word : line_ff[rd_addr_a];
      rd_b_in = (wr_en && (wr_addr == rd_addr_b)) ? wr_word : line_ff[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ff[wr_addr] <= wr_word;
      end
      rd_a_ff <= rd_a_in;
      rd_b_ff <= rd_b_in;
   end

   assign rd_a_height = rd_a_ff[WORD_W-1:2];
   assign rd_a_mark_l = rd_a_ff[1];
   assign rd_a_mark_r = rd_a_ff[0];
   assign rd_b_mark_l = rd_b_ff[1];

endmodule

// ===== rtl/gwpm_seq.sv =====
// Front stage: grid size registers, raster position, drain counter and row bank.
// Issues line memory reads on each accepted beat and registers the command. Uses gwpm_pkg.
module gwpm_seq
   import gwpm_pkg::*;
#(
   parameter int LINE_DEPTH  = 4096,
   parameter int LINE_AW     = 12,
   parameter int HEIGHT_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   func,
   input  logic [HEIGHT_BITS-1:0] elevation,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   output logic [LINE_AW:0]       rd_addr_a,
   output logic [LINE_AW:0]       rd_addr_b,
   output logic                   cmd_valid,
   output cmd_type                cmd,
   output logic [HEIGHT_BITS-1:0] key
);

   localparam logic [CFG_W-1:0] WIDTH_MAX = CFG_W'(LINE_DEPTH);

   logic [CFG_W-1:0]       width_ff, width_in;
   logic [CFG_W-1:0]       height_ff, height_in;
   logic [COORD_W-1:0]     row_ff, row_in;
   logic [COORD_W-1:0]     col_ff, col_in;
   logic [DRAIN_W-1:0]     drain_ff, drain_in;
   logic                   bank_ff, bank_in;
   logic                   cmd_valid_ff, cmd_valid_in;
   cmd_type                cmd_ff, cmd_in;
   logic [HEIGHT_BITS-1:0] key_ff, key_in;

   logic [COORD_W-1:0]     width_last, height_last;
   logic [DRAIN_W-1:0]     drain_clip;
   logic [CFG_W-1:0]       drain_col, drain_col_next;
   logic                   at_last_col;

   always_comb begin
      width_last     = COORD_W'(width_ff - CFG_W'(1));
      height_last    = COORD_W'(height_ff - CFG_W'(1));
      drain_clip     = (drain_ff > width_ff) ? width_ff : drain_ff;
      drain_col      = width_ff - drain_clip;
      drain_col_next = drain_col + CFG_W'(1);
      at_last_col    = (col_ff == width_last);
   end

   // reads go to the bank the previous row wrote
   always_comb begin
      if (func == FUNC_DRAIN) begin
         rd_addr_a = {~bank_ff, drain_col[LINE_AW-1:0]};
      end else begin
         rd_addr_a = {~bank_ff, col_ff[LINE_AW-1:0]};
      end
      rd_addr_b = {~bank_ff, drain_col_next[LINE_AW-1:0]};
   end

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      drain_in     = drain_ff;
      bank_in      = bank_ff;
      cmd_valid_in = accept;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  width_in  = clamp_dim(csr_wdata, WIDTH_MAX);
            CSR_GRID_HEIGHT: height_in = clamp_dim(csr_wdata, HEIGHT_MAX);
         endcase
         row_in   = '0;
         col_in   = '0;
         drain_in = '0;
      end else if (accept) begin
         key_in       = elevation;
         cmd_in.drain = (func == FUNC_DRAIN);
         cmd_in.bank  = bank_ff;
         if (func == FUNC_DRAIN) begin
            cmd_in.hit        = (drain_ff != '0);
            cmd_in.row        = height_last;
            cmd_in.col        = COORD_W'(drain_col);
            cmd_in.last_col   = (drain_clip == DRAIN_W'(1));
            cmd_in.frame_last = (drain_clip == DRAIN_W'(1));
            if (drain_ff != '0) begin
               drain_in = drain_clip - DRAIN_W'(1);
            end
         end else begin
            cmd_in.hit        = 1'b0;
            cmd_in.row        = row_ff;
            cmd_in.col        = col_ff;
            cmd_in.last_col   = at_last_col;
            cmd_in.frame_last = 1'b0;
            if (at_last_col) begin
               col_in  = '0;
               bank_in = ~bank_ff;
               if (row_ff == '0) begin
                  drain_in = '0;
               end
               // end of frame: last row waits for drain beats
               if (row_ff == height_last) begin
                  row_in   = '0;
                  drain_in = width_ff;
               end else begin
                  row_in = row_ff + COORD_W'(1);
               end
            end else begin
               col_in = col_ff + COORD_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= clamp_dim(DIM_RESET, WIDTH_MAX);
         height_ff    <= clamp_dim(DIM_RESET, HEIGHT_MAX);
         row_ff       <= '0;
         col_ff       <= '0;
         drain_ff     <= '0;
         bank_ff      <= 1'b0;
         cmd_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         drain_ff     <= drain_in;
         bank_ff      <= bank_in;
         cmd_valid_ff <= cmd_valid_in;
      end
      cmd_ff <= cmd_in;
      key_ff <= key_in;
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;
   assign key       = key_ff;

endmodule

// ===== rtl/gwpm_window.sv =====
// Window stage: 2x2 peak compare on line memory data, mark write-back, result forming.
// Consumes the command from gwpm_seq and read data from gwpm_line_mem. Uses gwpm_pkg.
module gwpm_window
   import gwpm_pkg::*;
#(
   parameter int LINE_AW     = 12,
   parameter int HEIGHT_BITS = 32
) (
   input  logic                   clock,
   input  logic                   cmd_valid,
   input  cmd_type                cmd,
   input  logic [HEIGHT_BITS-1:0] key,
   input  logic [HEIGHT_BITS-1:0] rd_a_height,
   input  logic                   rd_a_mark_l,
   input  logic                   rd_a_mark_r,
   input  logic                   rd_b_mark_l,
   output logic                   wr_en,
   output logic [LINE_AW:0]       wr_addr,
   output logic [HEIGHT_BITS-1:0] wr_height,
   output logic                   wr_mark_l,
   output logic                   wr_mark_r,
   output logic                   res0_valid,
   output result_type             res0,
   output logic                   res1_valid,
   output result_type             res1
);

   typedef enum logic [1:0] {
      POS_TL,
      POS_TR,
      POS_BL,
      POS_BR
   } pos_type;

   logic [HEIGHT_BITS-1:0] prev_height_ff, prev_height_in;
   logic                   prev_mark_r_ff, prev_mark_r_in;
   logic                   prev_tr_ff, prev_tr_in;
   logic [HEIGHT_BITS-1:0] left_ff, left_in;

   logic                   sample, has_win;
   pos_type                top_pos, bot_pos, best;
   logic [HEIGHT_BITS-1:0] top_max, bot_max;
   logic                   mark_tl, mark_tr, mark_bl, mark_br;

   // pairwise then final compare; strict greater keeps the earlier position on ties
   always_comb begin
      if ($signed(rd_a_height) > $signed(prev_height_ff)) begin
         top_pos = POS_TR;
         top_max = rd_a_height;
      end else begin
         top_pos = POS_TL;
         top_max = prev_height_ff;
      end
      if ($signed(key) > $signed(left_ff)) begin
         bot_pos = POS_BR;
         bot_max = key;
      end else begin
         bot_pos = POS_BL;
         bot_max = left_ff;
      end
      best = ($signed(bot_max) > $signed(top_max)) ? bot_pos : top_pos;
   end

   always_comb begin
      sample  = cmd_valid && !cmd.drain;
      has_win = sample && (cmd.col != '0) && (cmd.row != '0);
      mark_tl = has_win && (best == POS_TL);
      mark_tr = has_win && (best == POS_TR);
      mark_bl = has_win && (best == POS_BL);
      mark_br = has_win && (best == POS_BR);
   end

   // entry c keeps the new row's height, the mark its window put on column c-1
   // (bottom-left) and the one it put on column c (bottom-right)
   always_comb begin
      wr_en     = sample;
      wr_addr   = {cmd.bank, cmd.col[LINE_AW-1:0]};
      wr_height = key;
      wr_mark_l = mark_bl;
      wr_mark_r = mark_br;
   end

   always_comb begin
      res0_valid = 1'b0;
      res0       = '0;
      res1_valid = 1'b0;
      res1       = '0;
      if (cmd_valid && cmd.drain) begin
         res0_valid      = cmd.hit;
         res0.pixel_row  = cmd.row;
         res0.pixel_col  = cmd.col;
         res0.peak_flag  = rd_a_mark_r || (!cmd.last_col && rd_b_mark_l);
         res0.frame_last = cmd.frame_last;
      end else begin
         res0_valid      = has_win;
         res0.pixel_row  = cmd.row - COORD_W'(1);
         res0.pixel_col  = cmd.col - COORD_W'(1);
         res0.peak_flag  = prev_mark_r_ff || rd_a_mark_l || mark_tl || prev_tr_ff;
         res0.frame_last = 1'b0;
         res1_valid      = sample && cmd.last_col && (cmd.row != '0);
         res1.pixel_row  = cmd.row - COORD_W'(1);
         res1.pixel_col  = cmd.col;
         res1.peak_flag  = rd_a_mark_r || mark_tr;
         res1.frame_last = 1'b0;
      end
   end

   always_comb begin
      prev_height_in = prev_height_ff;
      prev_mark_r_in = prev_mark_r_ff;
      prev_tr_in     = prev_tr_ff;
      left_in        = left_ff;
      if (sample) begin
         prev_height_in = rd_a_height;
         prev_mark_r_in = rd_a_mark_r;
         prev_tr_in     = mark_tr;
         left_in        = key;
      end
   end

   always_ff @(posedge clock) begin
      prev_height_ff <= prev_height_in;
      prev_mark_r_ff <= prev_mark_r_in;
      prev_tr_ff     <= prev_tr_in;
      left_ff        <= left_in;
   end

endmodule

// ===== rtl/gwpm_rsp_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per beat.
// Reports whether it can absorb two more worst-case input beats. Uses gwpm_pkg.
module gwpm_rsp_fifo
   import gwpm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push0_valid,
   input  result_type push0,
   input  logic       push1_valid,
   input  result_type push1,
   input  logic       pop,
   output logic       head_valid,
   output result_type head,
   output logic       room
);

   localparam int CNT_W = RSP_FIFO_AW + 1;

   result_type             slot_ff [RSP_FIFO_DEPTH];
   logic [RSP_FIFO_AW-1:0] head_ff, head_in;
   logic [RSP_FIFO_AW-1:0] tail_ff, tail_in;
   logic [RSP_FIFO_AW-1:0] tail_next;
   logic [CNT_W-1:0]       count_ff, count_in;

   always_comb begin
      tail_next = tail_ff + RSP_FIFO_AW'(1);
      head_in   = pop ? head_ff + RSP_FIFO_AW'(1) : head_ff;
      tail_in   = tail_ff + RSP_FIFO_AW'(push0_valid) + RSP_FIFO_AW'(push1_valid);
      count_in  = count_ff + CNT_W'(push0_valid) + CNT_W'(push1_valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push0_valid) begin
         slot_ff[tail_ff] <= push0;
      end
      if (push1_valid) begin
         slot_ff[tail_next] <= push1;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[head_ff];
   // one beat in the window stage plus the next one may each add two results
   assign room       = (count_ff <= CNT_W'(RSP_FIFO_DEPTH - 2 * MAX_RESULTS));

endmodule

// ===== rtl/grid_window_peak_marker_core.sv =====
// Grid window peak marker: takes one beat per clock (samples or drain ticks) as long as the
// 8-entry result queue has room for two more beats; a result leaves via the command register
// and result queue. Each sample reads one line memory entry in its accept cycle and writes one
// back the next cycle, so the single write port sets the rate of one beat per clock. The line
// memory holds 2 x 2**LINE_AW words, one bank per row in turn; entries are always written by
// one row before the next row reads them, so no clearing pass is needed after reset. A csr
// write restarts the frame; the user must issue it only when idle, the block does not enforce
// it. Depends on gwpm_pkg, gwpm_seq, gwpm_line_mem, gwpm_window and gwpm_rsp_fifo.
module grid_window_peak_marker_core
   import gwpm_pkg::*;
#(
   parameter int MAX_WIDTH   = 4096,
   parameter int HEIGHT_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((HEIGHT_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // elevation
   input  logic                                 req_tuser,  // func
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [RSP_TDATA_W-1:0]               rsp_tdata,  // pixel_row, pixel_col, peak_flag
   output logic                                 rsp_tlast,  // frame_last
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [CFG_W-1:0]                     csr_wdata
);

   localparam int LINE_DEPTH = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int RSP_PAD_W  = RSP_TDATA_W - (2 * COORD_W + 1);

   logic                   accept;
   logic [LINE_AW:0]       rd_addr_a, rd_addr_b;
   logic                   cmd_valid;
   cmd_type                cmd;
   logic [HEIGHT_BITS-1:0] key;
   logic [HEIGHT_BITS-1:0] rd_a_height;
   logic                   rd_a_mark_l, rd_a_mark_r, rd_b_mark_l;
   logic                   wr_en;
   logic [LINE_AW:0]       wr_addr;
   logic [HEIGHT_BITS-1:0] wr_height;
   logic                   wr_mark_l, wr_mark_r;
   logic                   res0_valid, res1_valid;
   result_type             res0, res1;
   logic                   room;
   result_type             head;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = room;

   gwpm_seq #(
      .LINE_DEPTH  (LINE_DEPTH),
      .LINE_AW     (LINE_AW),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_tuser),
      .elevation (req_tdata[HEIGHT_BITS-1:0]),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .key       (key)
   );

   gwpm_line_mem #(
      .LINE_AW     (LINE_AW),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_line_mem (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_height   (wr_height),
      .wr_mark_l   (wr_mark_l),
      .wr_mark_r   (wr_mark_r),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .rd_a_height (rd_a_height),
      .rd_a_mark_l (rd_a_mark_l),
      .rd_a_mark_r (rd_a_mark_r),
      .rd_b_mark_l (rd_b_mark_l)
   );

   gwpm_window #(
      .LINE_AW     (LINE_AW),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_window (
      .clock       (clock),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .key         (key),
      .rd_a_height (rd_a_height),
      .rd_a_mark_l (rd_a_mark_l),
      .rd_a_mark_r (rd_a_mark_r),
      .rd_b_mark_l (rd_b_mark_l),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_height   (wr_height),
      .wr_mark_l   (wr_mark_l),
      .wr_mark_r   (wr_mark_r),
      .res0_valid  (res0_valid),
      .res0        (res0),
      .res1_valid  (res1_valid),
      .res1        (res1)
   );

   gwpm_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push0_valid (res0_valid),
      .push0       (res0),
      .push1_valid (res1_valid),
      .push1       (res1),
      .pop         (rsp_tvalid && rsp_tready),
      .head_valid  (rsp_tvalid),
      .head        (head),
      .room        (room)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, head.peak_flag, head.pixel_col, head.pixel_row};
   assign rsp_tlast = head.frame_last;

endmodule

// ===== dv/grid_window_peak_marker_core_tb.sv =====
// Self-checking testbench for grid_window_peak_marker_core: stream beats in, check pixel marks out.
// Carries its own predictor of the 2x2 window peak marking and drives the csr port between phases.
// Depends on gwpm_pkg and the RTL of grid_window_peak_marker_core.
module grid_window_peak_marker_core_tb;
   import gwpm_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_LATENCY = 8;
   localparam int RANDOM_SAMPLES = 450;

   typedef struct packed {
      logic        func;
      logic [31:0] elevation;
      logic        hold;  // wait until all marks are back before sending
   } grid_beat;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;
   logic              req_tuser = FUNC_SAMPLE;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic              rsp_tlast;
   logic              csr_we = 1'b0;
   logic              csr_index = CSR_GRID_WIDTH;
   logic [CFG_W-1:0]  csr_wdata = '0;

   grid_window_peak_marker_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   grid_beat   beats_to_send[$];
   result_type marked_pixels[$];
   result_type want_pixel;
   int         error_count = 0;
   int         cycle_count = 0;
   int         send_gap_pct = 0;
   int         stall_pct = 0;
   bit         beat_taken = 1'b0;

   // predictor state; keys are heights with the sign bit flipped so unsigned compare works
   bit [31:0]    line_keys [WIDTH_LIMIT];
   bit           upper_marks [WIDTH_LIMIT];
   bit           row_marks [WIDTH_LIMIT];
   bit [31:0]    left_key = '0;
   int unsigned  next_row = 0;
   int unsigned  next_col = 0;
   int unsigned  drain_left = 0;
   bit [CFG_W-1:0] width_reg = DIM_RESET;
   bit [CFG_W-1:0] height_reg = DIM_RESET;
   // marks only ever land below the widest width used so far
   int unsigned  mark_span = DIM_RESET;

   function automatic int unsigned clip_dim(bit [CFG_W-1:0] v);
      if (v < 2) return 2;
      if (v > 4096) return 4096;
      return v;
   endfunction

   function automatic void expect_pixel(int unsigned r, int unsigned c, bit flag, bit last);
      result_type p;
      p.pixel_row  = r[COORD_W-1:0];
      p.pixel_col  = c[COORD_W-1:0];
      p.peak_flag  = flag;
      p.frame_last = last;
      marked_pixels.push_back(p);
   endfunction

   function automatic void apply_csr(logic idx, bit [CFG_W-1:0] val);
      if (idx == CSR_GRID_WIDTH) width_reg = val;
      else height_reg = val;
      next_row = 0;
      next_col = 0;
      drain_left = 0;
      if (clip_dim(width_reg) > mark_span) mark_span = clip_dim(width_reg);
   endfunction

   function automatic void predict_beat(grid_beat b);
      int unsigned w, h, r, c, best, i;
      bit [31:0]   key;
      bit [31:0]   win [4];
      w = clip_dim(width_reg);
      h = clip_dim(height_reg);
      if (b.func == FUNC_DRAIN) begin
         if (drain_left != 0) begin
            if (drain_left > w) drain_left = w;
            c = w - drain_left;
            drain_left--;
            expect_pixel(h - 1, c, upper_marks[c], drain_left == 0);
         end
      end else begin
         key = b.elevation ^ 32'h8000_0000;
         r = (next_row >= h) ? h - 1 : next_row;
         c = (next_col >= w) ? w - 1 : next_col;
         if (c > 0) begin
            if (r > 0) begin
               win[0] = line_keys[c-1];
               win[1] = line_keys[c];
               win[2] = left_key;
               win[3] = key;
               best = 0;
               // strict compare: ties go to the earlier window position
               for (i = 1; i < 4; i++) begin
                  if (win[i] > win[best]) best = i;
               end
               case (best)
                  0: upper_marks[c-1] = 1'b1;
                  1: upper_marks[c] = 1'b1;
                  2: row_marks[c-1] = 1'b1;
                  default: row_marks[c] = 1'b1;
               endcase
               expect_pixel(r - 1, c - 1, upper_marks[c-1], 1'b0);
            end
            line_keys[c-1] = left_key;
         end
         left_key = key;
         if (c == w - 1) begin
            if (r > 0) expect_pixel(r - 1, c, upper_marks[c], 1'b0);
            line_keys[c] = key;
            // leftover last row of the previous frame is dropped once row 0 ends
            if (r == 0) drain_left = 0;
            for (i = 0; i < mark_span; i++) begin
               upper_marks[i] = row_marks[i];
               row_marks[i] = 1'b0;
            end
            next_col = 0;
            if (r == h - 1) begin
               next_row = 0;
               drain_left = w;
            end else begin
               next_row = r + 1;
            end
         end else begin
            next_col = c + 1;
            next_row = r;
         end
      end
   endfunction

   function automatic bit [31:0] pick_height();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3, 4: return $urandom;
         default: return $urandom_range(0, 6) - 3;  // narrow range, lots of ties
      endcase
   endfunction

   function automatic void queue_beat(logic func, bit [31:0] elev, bit hold);
      grid_beat b;
      b.func = func;
      b.elevation = elev;
      b.hold = hold;
      beats_to_send.push_back(b);
   endfunction

   function automatic void queue_frame(int unsigned n_samples, int unsigned n_drains,
                                       int unsigned noise_pct, bit hold_first);
      int unsigned k;
      for (k = 0; k < n_samples; k++) begin
         if ($urandom_range(0, 99) < noise_pct) queue_beat(FUNC_DRAIN, pick_height(), 1'b0);
         queue_beat(FUNC_SAMPLE, pick_height(), hold_first && k == 0);
      end
      for (k = 0; k < n_drains; k++) queue_beat(FUNC_DRAIN, pick_height(), 1'b0);
   endfunction

   function automatic void set_idling(int mode);
      case (mode)
         1: begin send_gap_pct = 49; stall_pct = 0; end
         2: begin send_gap_pct = 0; stall_pct = 49; end
         3: begin send_gap_pct = 6; stall_pct = 6; end
         default: begin send_gap_pct = 0; stall_pct = 0; end
      endcase
   endfunction

   task automatic settle();
      while (beats_to_send.size() != 0 || marked_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_LATENCY) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, bit [CFG_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_csr(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // driver: new values at the falling edge; a raised valid holds until its beat is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !beat_taken) begin
      end else if (beats_to_send.size() != 0
                   && !(beats_to_send[0].hold && marked_pixels.size() != 0)
                   && $urandom_range(0, 99) >= send_gap_pct) begin
         req_tvalid <= 1'b1;
         req_tuser <= beats_to_send[0].func;
         req_tdata <= beats_to_send[0].elevation;
      end else begin
         req_tvalid <= 1'b0;
         req_tuser <= $urandom_range(0, 1);
         req_tdata <= $urandom;
      end
      beat_taken = 1'b0;
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // monitor: results are checked before the beat of the same edge is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (marked_pixels.size() == 0) begin
               error_count++;
               $error("unexpected result beat: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            end else begin
               want_pixel = marked_pixels.pop_front();
               if (rsp_tdata[11:0] != want_pixel.pixel_row) begin
                  error_count++;
                  $error("pixel_row: expected %0d, got %0d", want_pixel.pixel_row,
                         rsp_tdata[11:0]);
               end
               if (rsp_tdata[23:12] != want_pixel.pixel_col) begin
                  error_count++;
                  $error("pixel_col: expected %0d, got %0d", want_pixel.pixel_col,
                         rsp_tdata[23:12]);
               end
               if (rsp_tdata[24] != want_pixel.peak_flag) begin
                  error_count++;
                  $error("peak_flag: expected %0d, got %0d", want_pixel.peak_flag,
                         rsp_tdata[24]);
               end
               if (rsp_tlast != want_pixel.frame_last) begin
                  error_count++;
                  $error("frame_last: expected %0d, got %0d", want_pixel.frame_last,
                         rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_beat(beats_to_send[0]);
            void'(beats_to_send.pop_front());
            beat_taken = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("grid_window_peak_marker_core test failed");
         $finish;
      end
   end

   initial begin
      int seg;
      int unsigned sample_count, w, h, n, drains;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset geometry: a couple of row 0 samples, then a drain with nothing pending
      queue_beat(FUNC_SAMPLE, 32'd5, 1'b0);
      queue_beat(FUNC_SAMPLE, -32'sd7, 1'b0);
      queue_beat(FUNC_DRAIN, 32'd0, 1'b0);
      settle();

      // out-of-range values clamp to a 2x2 grid; flat frame, every window ties
      write_csr(CSR_GRID_WIDTH, 13'd0);
      write_csr(CSR_GRID_HEIGHT, 13'd1);
      repeat (4) queue_beat(FUNC_SAMPLE, 32'd0, 1'b0);
      repeat (3) queue_beat(FUNC_DRAIN, 32'd0, 1'b0);
      settle();

      // 3x2: height extremes, then a drain cut short by the next frame's row 0
      write_csr(CSR_GRID_WIDTH, 13'd3);
      queue_beat(FUNC_SAMPLE, 32'h8000_0000, 1'b0);
      queue_beat(FUNC_SAMPLE, 32'h7fff_ffff, 1'b0);
      queue_beat(FUNC_SAMPLE, 32'hffff_ffff, 1'b0);
      queue_beat(FUNC_SAMPLE, 32'h0000_0000, 1'b0);
      queue_beat(FUNC_SAMPLE, 32'h7fff_ffff, 1'b0);
      queue_beat(FUNC_SAMPLE, 32'h7fff_ffff, 1'b0);
      queue_beat(FUNC_DRAIN, 32'd0, 1'b0);
      queue_beat(FUNC_SAMPLE, 32'd1, 1'b0);
      queue_beat(FUNC_SAMPLE, 32'd2, 1'b0);
      queue_beat(FUNC_DRAIN, 32'd0, 1'b0);
      queue_beat(FUNC_SAMPLE, 32'd3, 1'b0);
      queue_beat(FUNC_DRAIN, 32'd0, 1'b0);
      queue_beat(FUNC_SAMPLE, 32'd4, 1'b1);
      queue_beat(FUNC_SAMPLE, 32'd4, 1'b0);
      queue_beat(FUNC_SAMPLE, 32'd9, 1'b0);
      repeat (3) queue_beat(FUNC_DRAIN, 32'd0, 1'b0);
      settle();

      // tallest grid, two columns
      set_idling(3);
      write_csr(CSR_GRID_WIDTH, 13'd2);
      write_csr(CSR_GRID_HEIGHT, 13'h1fff);
      queue_frame(2 * 4096, 2, 0, 1'b0);
      settle();

      // widest grid, two rows
      set_idling(0);
      write_csr(CSR_GRID_WIDTH, 13'h1fff);
      write_csr(CSR_GRID_HEIGHT, 13'd2);
      queue_frame(2 * 4096, 4096, 0, 1'b0);
      settle();

      seg = 0;
      sample_count = 0;
      while (sample_count < RANDOM_SAMPLES) begin
         set_idling(seg % 4);
         if ($urandom_range(0, 3) != 0) begin
            settle();
            write_csr(CSR_GRID_WIDTH, $urandom_range(0, 7));
         end
         if ($urandom_range(0, 3) != 0) begin
            settle();
            write_csr(CSR_GRID_HEIGHT, $urandom_range(0, 5));
         end
         w = clip_dim(width_reg);
         h = clip_dim(height_reg);
         n = w * h;
         if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
         drains = w;
         case ($urandom_range(0, 5))
            0: drains = $urandom_range(0, w);
            1: drains = w + 2;
            default: ;
         endcase
         queue_frame(n, drains, $urandom_range(0, 1) ? 0 : 8, seg % 5 == 0);
         sample_count += n;
         seg++;
      end

      settle();
      if (error_count == 0 && marked_pixels.size() == 0) begin
         $display("grid_window_peak_marker_core test passed");
      end else begin
         $display("grid_window_peak_marker_core test failed");
      end
      $finish;
   end

endmodule
